// ===== rtl/core/round_robin_process_scheduler_assert.svh =====
// assertion helpers for the round-robin scheduler
// the including module provides clk and rst_n
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define RRPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrps assertion failed");

// next-cycle implication
`define RRPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrps assertion failed");

`endif

// ===== rtl/core/rrps_pkg.sv =====
// ----------------------------------------------------------------------------
// rrps_pkg
// Types and constants shared by the round-robin scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrps_pkg;

  localparam int DEF_MAX_PROCS     = 16;
  localparam int DEF_FRACTION_BITS = 8;
  localparam int WT_W              = 40;
  localparam int CFG_ADDR_W        = 3;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_DISPATCH = 3'd0,
    ST_IDLE     = 3'd1,
    ST_ALL_DONE = 3'd2,
    ST_LOADED   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_REQ,
    S_HEAD_RD,
    S_TBL_RD,
    S_DISP,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] arrival_time;
    logic [15:0] service_time;
  } in_item_t;

  typedef struct packed {
    status_t         status;
    logic [3:0]      proc_index;
    logic [31:0]     slice_start;
    logic [15:0]     slice_length;
    logic            first_dispatch;
    logic            finished;
    logic [31:0]     finish_time;
    logic [31:0]     turnaround;
    logic [WT_W-1:0] weighted_turnaround;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrps_div.sv =====
// ----------------------------------------------------------------------------
// rrps_div
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrps_div #(
  parameter int QW = 40
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [QW-1:0] dividend,
  input  wire logic [15:0]   divisor,
  output logic               done,
  output logic [QW-1:0]      quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [15:0]   rem_r;
  logic [QW-1:0] q_r;
  logic [15:0]   dvs_r;
  logic [16:0]   trial;
  logic          qbit;

  assign trial = {rem_r, q_r[QW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
      q_r   <= {q_r[QW-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/round_robin_process_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// Round-robin scheduler over a table of loaded processes.
// ----------------------------------------------------------------------------
// One item at a time. Load finishes through the result stage; clear and unused
// codes return to idle directly. A step visits each loaded entry (table read,
// compare) plus a closing step, and rescans after every admission; dispatch
// then reads the queue head and the table entry, and a finishing slice waits
// for the bit-serial divider. The table is read one entry at a time, which
// sets the scan cost. Results wait in an output register.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_process_scheduler #(
  parameter int MAX_PROCS     = rrps_pkg::DEF_MAX_PROCS,
  parameter int FRACTION_BITS = rrps_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire rrps_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rrps_pkg::out_item_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rrps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int QW    = 32 + FRACTION_BITS;
  localparam int WT_W  = rrps_pkg::WT_W;

  rrps_pkg::state_t    state_r, state_nxt;
  rrps_pkg::out_item_t res_r, out_r, res_idle;
  logic                out_valid_r;

  logic [15:0]          quantum_r;
  logic [CNT_W-1:0]     loaded_r, completed_r, count_r, scan_r;
  logic [IDX_W-1:0]     head_r, tail_r, best_r, requeue_idx_r;
  logic [MAX_PROCS-1:0] admitted_r, dispatched_r;
  logic                 requeue_pend_r, found_r;
  logic [31:0]          time_r, best_key_r;

  // table memory: arrival, service, remaining
  logic [47:0]      tbl_mem [MAX_PROCS];
  logic [47:0]      tbl_rdata_r;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [47:0]      tbl_wdata;

  // ready queue memory
  logic [IDX_W-1:0] fifo_mem [MAX_PROCS];
  logic [IDX_W-1:0] fifo_rdata_r;
  logic             fifo_we;
  logic [IDX_W-1:0] fifo_wdata;

  logic             in_xfer, cfg_wr, scan_end, cand, better;
  logic [IDX_W-1:0] scan_idx;
  logic [15:0]      svc_in, q_eff, rem, run, rem_n, arr, svc;
  logic [31:0]      time_n, ta;
  logic [CNT_W-1:0] req_cnt;
  logic             div_start, div_done;
  logic [QW-1:0]    div_quot;
  logic             wt_sat;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    r = (p == IDX_W'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != rrps_pkg::S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr == '0) ? {16'b0, quantum_r} : 32'b0;

  assign scan_idx = scan_r[IDX_W-1:0];
  assign scan_end = (scan_r >= loaded_r);
  assign arr      = tbl_rdata_r[47:32];
  assign svc      = tbl_rdata_r[31:16];
  assign rem      = tbl_rdata_r[15:0];
  assign cand     = !admitted_r[scan_idx] && ({16'b0, arr} <= time_r);
  assign better   = !found_r || ({arr, svc} < best_key_r);
  assign svc_in   = (in_data.service_time == 16'd0) ? 16'd1 : in_data.service_time;
  assign q_eff    = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign run      = (rem < q_eff) ? rem : q_eff;
  assign rem_n    = rem - run;
  assign time_n   = time_r + {16'b0, run};
  assign ta       = time_n - {16'b0, arr};
  assign req_cnt  = count_r + CNT_W'(requeue_pend_r);
  assign div_start = (state_r == rrps_pkg::S_DISP) && (rem_n == 16'd0);
  assign wt_sat   = |(div_quot >> WT_W);

  rrps_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (QW'(ta) << FRACTION_BITS),
    .divisor  (svc),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrps_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (in_data.action)
            rrps_pkg::ACT_LOAD: state_nxt = rrps_pkg::S_FIN;
            rrps_pkg::ACT_STEP: begin
              state_nxt = (completed_r >= loaded_r) ? rrps_pkg::S_FIN
                                                    : rrps_pkg::S_SCAN_RD;
            end
            rrps_pkg::ACT_CLEAR,
            rrps_pkg::ACT_NONE: state_nxt = rrps_pkg::S_IDLE;
          endcase
        end
      end
      rrps_pkg::S_SCAN_RD: begin
        if (!scan_end) begin
          state_nxt = rrps_pkg::S_SCAN_CMP;
        end else if (!found_r) begin
          state_nxt = rrps_pkg::S_REQ;
        end
      end
      rrps_pkg::S_SCAN_CMP: state_nxt = rrps_pkg::S_SCAN_RD;
      rrps_pkg::S_REQ: begin
        state_nxt = (req_cnt == '0) ? rrps_pkg::S_FIN : rrps_pkg::S_HEAD_RD;
      end
      rrps_pkg::S_HEAD_RD: state_nxt = rrps_pkg::S_TBL_RD;
      rrps_pkg::S_TBL_RD:  state_nxt = rrps_pkg::S_DISP;
      rrps_pkg::S_DISP: begin
        state_nxt = (rem_n == 16'd0) ? rrps_pkg::S_DIV : rrps_pkg::S_FIN;
      end
      rrps_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = rrps_pkg::S_FIN;
        end
      end
      rrps_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = rrps_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrps_pkg::S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    tbl_we     = 1'b0;
    tbl_waddr  = fifo_rdata_r;
    tbl_wdata  = {arr, svc, rem_n};
    tbl_raddr  = '0;
    fifo_we    = 1'b0;
    fifo_wdata = best_r;
    unique case (state_r)
      rrps_pkg::S_IDLE: begin
        tbl_waddr = loaded_r[IDX_W-1:0];
        tbl_wdata = {in_data.arrival_time, svc_in, svc_in};
        tbl_we    = in_xfer && (in_data.action == rrps_pkg::ACT_LOAD) &&
                    (loaded_r < CNT_W'(MAX_PROCS));
      end
      rrps_pkg::S_SCAN_RD: begin
        tbl_raddr = scan_idx;
        fifo_we   = scan_end && found_r;
      end
      rrps_pkg::S_REQ: begin
        fifo_we    = requeue_pend_r;
        fifo_wdata = requeue_idx_r;
      end
      rrps_pkg::S_TBL_RD: tbl_raddr = fifo_rdata_r;
      rrps_pkg::S_DISP:   tbl_we    = 1'b1;
      rrps_pkg::S_SCAN_CMP, rrps_pkg::S_HEAD_RD,
      rrps_pkg::S_DIV, rrps_pkg::S_FIN: ;
      default: ;
    endcase
  end

  // result of an item that finishes straight from idle
  always_comb begin
    res_idle = '0;
    if (in_data.action == rrps_pkg::ACT_LOAD) begin
      if (loaded_r < CNT_W'(MAX_PROCS)) begin
        res_idle.status     = rrps_pkg::ST_LOADED;
        res_idle.proc_index = 4'(loaded_r[IDX_W-1:0]);
      end else begin
        res_idle.status = rrps_pkg::ST_FULL;
      end
    end else begin
      res_idle.status      = rrps_pkg::ST_ALL_DONE;
      res_idle.slice_start = time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_r <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail_r] <= fifo_wdata;
    end
    fifo_rdata_r <= fifo_mem[head_r];
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= rrps_pkg::S_IDLE;
      quantum_r      <= 16'd1;
      loaded_r       <= '0;
      completed_r    <= '0;
      count_r        <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      admitted_r     <= '0;
      dispatched_r   <= '0;
      requeue_pend_r <= 1'b0;
      requeue_idx_r  <= '0;
      time_r         <= '0;
      out_valid_r    <= 1'b0;
      scan_r         <= '0;
      found_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && paddr == '0) begin
        quantum_r <= pwdata[15:0];
      end
      priority if (state_r == rrps_pkg::S_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
      unique case (state_r)
        rrps_pkg::S_IDLE: begin
          if (in_xfer) begin
            scan_r  <= '0;
            found_r <= 1'b0;
            if (tbl_we) begin
              loaded_r <= loaded_r + 1'b1;
            end
            if (in_data.action == rrps_pkg::ACT_CLEAR) begin
              loaded_r       <= '0;
              completed_r    <= '0;
              count_r        <= '0;
              head_r         <= '0;
              tail_r         <= '0;
              admitted_r     <= '0;
              dispatched_r   <= '0;
              requeue_pend_r <= 1'b0;
              requeue_idx_r  <= '0;
              time_r         <= '0;
            end
          end
        end
        rrps_pkg::S_SCAN_RD: begin
          if (scan_end && found_r) begin
            admitted_r[best_r] <= 1'b1;
            tail_r  <= ptr_inc(tail_r);
            count_r <= count_r + 1'b1;
            scan_r  <= '0;
            found_r <= 1'b0;
          end
        end
        rrps_pkg::S_SCAN_CMP: begin
          if (cand && better) begin
            found_r <= 1'b1;
          end
          scan_r <= scan_r + 1'b1;
        end
        rrps_pkg::S_REQ: begin
          count_r        <= req_cnt;
          requeue_pend_r <= 1'b0;
          if (requeue_pend_r) begin
            tail_r <= ptr_inc(tail_r);
          end
          if (req_cnt == '0) begin
            time_r <= time_r + 32'd1;
          end
        end
        rrps_pkg::S_DISP: begin
          head_r                     <= ptr_inc(head_r);
          count_r                    <= count_r - 1'b1;
          dispatched_r[fifo_rdata_r] <= 1'b1;
          time_r                     <= time_n;
          if (rem_n == 16'd0) begin
            completed_r <= completed_r + 1'b1;
          end else begin
            requeue_pend_r <= 1'b1;
            requeue_idx_r  <= fifo_rdata_r;
          end
        end
        rrps_pkg::S_HEAD_RD, rrps_pkg::S_TBL_RD, rrps_pkg::S_DIV,
        rrps_pkg::S_FIN: ;
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      rrps_pkg::S_IDLE: res_r <= res_idle;
      rrps_pkg::S_SCAN_CMP: begin
        if (cand && better) begin
          best_r     <= scan_idx;
          best_key_r <= {arr, svc};
        end
      end
      rrps_pkg::S_REQ: begin
        res_r.status       <= rrps_pkg::ST_IDLE;
        res_r.slice_start  <= time_r;
        res_r.slice_length <= 16'd1;
      end
      rrps_pkg::S_DISP: begin
        res_r.status         <= rrps_pkg::ST_DISPATCH;
        res_r.proc_index     <= 4'(fifo_rdata_r);
        res_r.slice_start    <= time_r;
        res_r.slice_length   <= run;
        res_r.first_dispatch <= !dispatched_r[fifo_rdata_r];
        res_r.finished       <= (rem_n == 16'd0);
        res_r.finish_time    <= (rem_n == 16'd0) ? time_n : 32'd0;
        res_r.turnaround     <= (rem_n == 16'd0) ? ta : 32'd0;
      end
      rrps_pkg::S_DIV: begin
        if (div_done) begin
          res_r.weighted_turnaround <= wt_sat ? {WT_W{1'b1}} : WT_W'(div_quot);
        end
      end
      rrps_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_r <= res_r;
        end
      end
      rrps_pkg::S_SCAN_RD, rrps_pkg::S_HEAD_RD, rrps_pkg::S_TBL_RD: ;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `include "round_robin_process_scheduler_assert.svh"

  `RRPS_ASSERT_NOW(a_queue_bound, 1'b1, count_r <= loaded_r)
  `RRPS_ASSERT_NOW(a_done_bound, 1'b1, completed_r <= loaded_r)
  `RRPS_ASSERT_NOW(a_div_in_wait, div_done, state_r == rrps_pkg::S_DIV)
  `RRPS_ASSERT_NEXT(a_disp_pops, state_r == rrps_pkg::S_DISP, count_r == $past(count_r) - 1'b1)

endmodule

`default_nettype wire
